// File: sv/kxc_pkg.sv
// shared types, constants and key table of the keyed xor chain byte cipher
package kxc_pkg;

	localparam int KEY_COUNT_DEF = 10;
	localparam int KEY_BYTES_DEF = 128;
	localparam int ROM_ROWS = 10;
	localparam int ROM_COLS = 128;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_KEY   = 2'd0,
		PH_START = 2'd1,
		PH_DATA  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_KEY   = 2'd1,
		ST_BAD_START = 2'd2
	} status_t;

	// one decoded request as it travels from the input stage to the result stage
	typedef struct packed {
		logic [1:0] nres;
		logic [7:0] hdr_key;
		logic [7:0] hdr_start;
		logic       set_prev;
		logic [7:0] prev_val;
		logic       is_data;
		logic       enc;
		logic [7:0] data;
		logic       last;
		status_t    status;
	} item_t;

	// first character sits in the top byte of each row
	localparam logic [ROM_COLS*8-1:0] KEY_ROWS [ROM_ROWS] = '{
		{"S3D5Lf6klfdsjiureLJKHLKmnblkjshgwieourLKHLKJHSDA0432175094SJAKLFK7",
		 "348LSDLKJDHFOIUhjgdskgfeiurytowelxcmnvbdfhgeoriyfdslkhgfdgyuie"},
		{"KlkjILKJ879IHKJ8kj67kjh7IUKJHjkh98769872vYUTui6JHG87jhg78JHg787JH",
		 "GUYuytuyjg876RHCVBnvbAIUT678787igJGFHGFTy67uhHJKJHUYTjhg6HGHG76"},
		{"4LKJH5Euhysdiouyfjlkw45879345kjshfdgcvxJSDHFR8734hdskmfv7y8KJLSDG",
		 "FAVBMZXBV789kMNADFYUYjhkgkjhdsgfowe787243KJHGDSAGJKkjgdfuye3sd7"},
		{"l45kjhdfuihlIUYSLKHi87ylKJHYOIUmsagKJLHgY9802734KJHLKiuoymNJHTmnb",
		 "4iU7687nkmbojyTD64654HJG765KHKJhg87jKHKJ76dcbnmbDBDSJFDHJ6IHGHJ"},
		{"fdlkhgljslfkdfhvcxzb 902374jklhfdgoIUOYLSKFDJH98798ysdlk9870OLHL9",
		 "87sdxmncosidHGKJ876kjhtdg786JHG87kj76Kjhgkjhi8K8HG98kgdnb mvzms"},
		{"lsdhflkasjhLKJHSLKHAFD987435LRKJHL34UY5L34J64MNB7IU4Yiuoyt87sdfjs",
		 "hg87ahjkjhgds87JHGKJHT8kjhgdfsvbmyt4eu678JHGkjyt6jKH78k0kjt02KJ"},
		{"lkjhUIYkljhlUYOI6yt9876HJMNBVuyt97JKHfMvhjytrfiyIUHGKVBMNBuyi9872",
		 "548JKN76kj9fsd8KHG8JKg7872732jK8JgkjhKJHGKJHgkjhg7jkhgkjhgkjhgk"},
		{"dsdfLKJH;LKjKJFLdJGmhpi657oU6Y76fhgf5dyfh879346nmzmbvc56erter654g",
		 "vcbmzwsdfdsmxcngfvRDFrEDfg76bDewdfvdfgwqsdfdgfcrRDfhgfderfdfteP"},
		{"lkhfdsRE546457djh6g65l67KJHLkhmnbvxcbDF09KLJliuyfdsgxcvbFDGERsdas",
		 "dfgTEdhFDtYrt8765DFRrfgfhvhghretwRF67654DFhDGFDVctTRTtrytrRyiTY"},
		{"28734jsdfhg873jksgUIYTIUkhgiuT7YIGVBKjg8796KHG8o76HJG876tKJHG8976",
		 "GFd6584H6G67RT987kJHG65978JKHG8JHGKJHGkhjgkjhgidsytf87439649283"}
	};

	// raw key byte, zero for rows past the table
	function automatic logic [7:0] key_byte(input logic [3:0] row, input logic [6:0] col);
		logic [ROM_COLS*8-1:0] row_bits;
		row_bits = '0;
		if (int'(row) < ROM_ROWS) begin
			row_bits = KEY_ROWS[row];
		end
		key_byte = row_bits[8*(ROM_COLS-1-int'(col)) +: 8];
	endfunction

endpackage

// File: sv/kxc_key_rom.sv
// key table with registered read port
module kxc_key_rom (
	input  logic       clk,
	input  logic       rd_en,
	input  logic [3:0] rd_row,
	input  logic [6:0] rd_col,
	output logic [7:0] rd_data
);

	logic [7:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= kxc_pkg::key_byte(rd_row, rd_col);
		end
	end

	assign rd_data = rd_data_s1;

endmodule

// File: sv/kxc_ctrl.sv
// request decode, header and key position state, input stage register
module kxc_ctrl #(
	parameter int KEY_COUNT = kxc_pkg::KEY_COUNT_DEF,
	parameter int KEY_BYTES = kxc_pkg::KEY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [7:0]        data_byte,
	input  logic              first_in,
	input  logic              last_in,
	input  logic [3:0]        key_select,
	input  logic [6:0]        start_position,
	input  logic              take_s1,
	output logic              valid_s1,
	output kxc_pkg::item_t    item_s1,
	output logic              rd_en,
	output logic [3:0]        rd_row,
	output logic [6:0]        rd_col
);

	logic               accept;
	logic               valid_q;
	kxc_pkg::item_t     item_q;
	kxc_pkg::item_t     item_d;
	logic [3:0]         key_q, key_d;
	logic [6:0]         off_q, off_d;
	kxc_pkg::phase_t    ph_q, ph_d, ph_use;
	logic               err_q, err_d, err_use;
	logic [3:0]         key_use;
	logic [6:0]         off_use;

	function automatic logic [6:0] advance(input logic [6:0] o);
		advance = (({1'b0, o} + 8'd1) >= 8'(KEY_BYTES)) ? 7'd0 : o + 7'd1;
	endfunction

	assign in_ready = !valid_q || take_s1;
	assign accept   = in_valid && in_ready;
	assign rd_en    = accept;
	assign rd_row   = key_use;
	assign rd_col   = off_use;
	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

	always_comb begin
		item_d          = '0;
		item_d.status   = kxc_pkg::ST_OK;
		key_d           = key_q;
		off_d           = off_q;
		ph_d            = ph_q;
		err_d           = err_q;
		key_use         = key_q;
		off_use         = off_q;
		ph_use          = ph_q;
		err_use         = err_q;
		item_d.data     = data_byte;
		item_d.last     = last_in;
		if (operation == kxc_pkg::OP_ENCRYPT) begin
			if (first_in) begin
				key_use = ({1'b0, key_select} >= 5'(KEY_COUNT)) ? 4'(KEY_COUNT - 1) : key_select;
				off_use = ({1'b0, start_position} >= 8'(KEY_BYTES)) ?
					7'(KEY_BYTES - 1) : start_position;
				err_d   = 1'b0;
			end
			item_d.nres      = first_in ? 2'd3 : 2'd1;
			item_d.hdr_key   = {4'd0, key_use};
			item_d.hdr_start = {1'b0, off_use};
			item_d.set_prev  = first_in;
			item_d.prev_val  = {1'b0, off_use};
			item_d.is_data   = 1'b1;
			item_d.enc       = 1'b1;
			key_d            = key_use;
			off_d            = advance(off_use);
			ph_d             = last_in ? kxc_pkg::PH_KEY : kxc_pkg::PH_DATA;
		end else begin
			if (first_in) begin
				err_use = 1'b0;
				ph_use  = kxc_pkg::PH_KEY;
				err_d   = 1'b0;
				ph_d    = kxc_pkg::PH_KEY;
			end
			if (err_use) begin
				// drop the rest of a rejected message
				if (last_in) begin
					err_d = 1'b0;
					ph_d  = kxc_pkg::PH_KEY;
				end
			end else begin
				case (ph_use)
					kxc_pkg::PH_KEY: begin
						if (data_byte >= 8'(KEY_COUNT)) begin
							item_d.nres   = 2'd1;
							item_d.last   = 1'b1;
							item_d.status = kxc_pkg::ST_BAD_KEY;
							err_d         = !last_in;
						end else begin
							key_d = data_byte[3:0];
							if (last_in) begin
								item_d.nres   = 2'd1;
								item_d.status = kxc_pkg::ST_BAD_START;
							end else begin
								ph_d = kxc_pkg::PH_START;
							end
						end
					end
					kxc_pkg::PH_START: begin
						if (data_byte >= 8'(KEY_BYTES)) begin
							item_d.nres   = 2'd1;
							item_d.last   = 1'b1;
							item_d.status = kxc_pkg::ST_BAD_START;
							err_d         = !last_in;
							ph_d          = kxc_pkg::PH_KEY;
						end else begin
							off_d           = data_byte[6:0];
							item_d.set_prev = 1'b1;
							item_d.prev_val = data_byte;
							if (last_in) begin
								item_d.nres = 2'd1;
								ph_d        = kxc_pkg::PH_KEY;
							end else begin
								ph_d = kxc_pkg::PH_DATA;
							end
						end
					end
					default: begin
						item_d.nres    = 2'd1;
						item_d.is_data = 1'b1;
						off_d          = advance(off_q);
						ph_d           = last_in ? kxc_pkg::PH_KEY : kxc_pkg::PH_DATA;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			key_q   <= '0;
			off_q   <= '0;
			ph_q    <= kxc_pkg::PH_KEY;
			err_q   <= 1'b0;
		end else begin
			if (accept) begin
				valid_q <= 1'b1;
				key_q   <= key_d;
				off_q   <= off_d;
				ph_q    <= ph_d;
				err_q   <= err_d;
			end else if (take_s1) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !item_q.is_data |-> (item_q.nres == 2'd0 || item_q.nres == 2'd1))
		else $error("status-only request carries more than one result");
`endif

endmodule

// File: sv/kxc_out.sv
// result stage: header sequencing, key xor and chaining, output register
module kxc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  kxc_pkg::item_t    item_s1,
	input  logic [7:0]        rom_s1,
	output logic              take_s1,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              data_valid,
	output logic              last_out,
	output logic [1:0]        status
);

	logic [1:0]         cnt_q;
	logic [7:0]         prev_q;
	kxc_pkg::item_t     item_s2;
	logic [7:0]         pad_s2;
	logic               load;
	logic               pop;
	logic               retire;
	logic [7:0]         chain;
	logic [7:0]         fin_byte;

	assign take_s1   = valid_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready));
	assign load      = take_s1 && item_s1.nres != 2'd0;
	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && out_ready;
	assign retire    = pop && cnt_q == 2'd1 && item_s2.is_data;

	// the final byte of a message is never chained
	assign chain    = item_s2.last ? 8'h00 : prev_q;
	assign fin_byte = item_s2.data ^ ~pad_s2 ^ chain;

	always_comb begin
		case (cnt_q)
			2'd3: begin
				out_byte   = item_s2.hdr_key;
				data_valid = 1'b1;
				last_out   = 1'b0;
				status     = kxc_pkg::ST_OK;
			end
			2'd2: begin
				out_byte   = item_s2.hdr_start;
				data_valid = 1'b1;
				last_out   = 1'b0;
				status     = kxc_pkg::ST_OK;
			end
			default: begin
				out_byte   = item_s2.is_data ? fin_byte : 8'h00;
				data_valid = item_s2.is_data;
				last_out   = item_s2.last;
				status     = item_s2.status;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			prev_q <= '0;
		end else begin
			if (take_s1) begin
				cnt_q <= item_s1.nres;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
			if (take_s1 && item_s1.set_prev) begin
				prev_q <= item_s1.prev_val;
			end else if (retire) begin
				prev_q <= item_s2.enc ? fin_byte : item_s2.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= item_s1;
			pad_s2  <= rom_s1;
		end
	end

`ifndef NO_ASSERTIONS
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> last_out)
		else $error("status-only result not marked last");
	a_hdr_key_next: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd3 && out_ready |=> cnt_q == 2'd2)
		else $error("start byte does not follow key byte");
	a_hdr_data_next: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && out_ready |=> cnt_q == 2'd1 && out_valid && data_valid)
		else $error("header not followed by a data byte");
`endif

endmodule

// File: sv/keyed_xor_chain_byte_cipher.sv
// top level of the keyed xor chain byte cipher
//
// input channel: in_valid/in_ready carry one request per byte: operation,
// data_byte, first_in/last_in message marks, and on an encrypt first byte the
// key_select and start_position. output channel: out_valid/out_ready carry one
// result: out_byte, data_valid, last_out, status.
// an encrypt request gives one cipher byte; on the first byte of a message it
// is preceded by the key number and start position header bytes. a decrypt
// request gives one plain byte, nothing for good header bytes and dropped
// bytes, or a single status-only result for a bad or truncated header or a
// message that ends on its start byte. an accepted request passes the input
// register (with the key table read), then the result register.
// requests are taken one per cycle while the receiver is ready and each gives
// at most one result; an encrypt first byte holds the result register until
// its three results have left by the single output port.
// a stalled receiver holds the result register; one more request waits in the
// input register, then in_ready drops. reset clears the key, position, header
// and chain state and empties both registers.
module keyed_xor_chain_byte_cipher #(
	parameter int KEY_COUNT = kxc_pkg::KEY_COUNT_DEF,
	parameter int KEY_BYTES = kxc_pkg::KEY_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] data_byte,
	input  logic       first_in,
	input  logic       last_in,
	input  logic [3:0] key_select,
	input  logic [6:0] start_position,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       data_valid,
	output logic       last_out,
	output logic [1:0] status
);

	// stage one request and its key byte
	logic               valid_s1;
	kxc_pkg::item_t     item_s1;
	logic               take_s1;
	logic               rd_en;
	logic [3:0]         rd_row;
	logic [6:0]         rd_col;
	logic [7:0]         rom_s1;

	// decode against header phase, key and position state
	kxc_ctrl #(
		.KEY_COUNT (KEY_COUNT),
		.KEY_BYTES (KEY_BYTES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_byte      (data_byte),
		.first_in       (first_in),
		.last_in        (last_in),
		.key_select     (key_select),
		.start_position (start_position),
		.take_s1        (take_s1),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.rd_en          (rd_en),
		.rd_row         (rd_row),
		.rd_col         (rd_col)
	);

	// key byte read in step with the input register
	kxc_key_rom u_rom (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_row  (rd_row),
		.rd_col  (rd_col),
		.rd_data (rom_s1)
	);

	// header bytes, key xor, chaining, result register
	kxc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.rom_s1     (rom_s1),
		.take_s1    (take_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.data_valid (data_valid),
		.last_out   (last_out),
		.status     (status)
	);

endmodule

// File: dv/tb_keyed_xor_chain_byte_cipher.sv
// keyed xor chain byte cipher bench: directed and random requests checked against a cipher predictor
`timescale 1ns / 1ps

// one request as offered on the input channel
typedef struct packed {
	kxc_pkg::op_t op;
	logic [7:0]   data;
	logic         first;
	logic         last;
	logic [3:0]   key_sel;
	logic [6:0]   start;
} cipher_request_t;

// one result as seen on the output channel
typedef struct packed {
	logic [7:0]       text;
	logic             data_valid;
	logic             last;
	kxc_pkg::status_t status;
} cipher_result_t;

// cipher predictor plus the queue of results still owed by the block
class cipher_scoreboard;
	logic [1023:0]   key_rows [10];
	logic [3:0]      cur_key;
	logic [6:0]      key_pos;
	logic [7:0]      chain;
	kxc_pkg::phase_t phase;
	bit              hold_errors;
	cipher_result_t  pending [$];
	int              mismatches;
	int              accepted;

	function new();
		// first character in the top byte, same layout as the key table
		key_rows[0] = {"S3D5Lf6klfdsjiureLJKHLKmnblkjshgwieourLKHLKJHSDA0432175094SJAKLFK7",
			"348LSDLKJDHFOIUhjgdskgfeiurytowelxcmnvbdfhgeoriyfdslkhgfdgyuie"};
		key_rows[1] = {"KlkjILKJ879IHKJ8kj67kjh7IUKJHjkh98769872vYUTui6JHG87jhg78JHg787JH",
			"GUYuytuyjg876RHCVBnvbAIUT678787igJGFHGFTy67uhHJKJHUYTjhg6HGHG76"};
		key_rows[2] = {"4LKJH5Euhysdiouyfjlkw45879345kjshfdgcvxJSDHFR8734hdskmfv7y8KJLSDG",
			"FAVBMZXBV789kMNADFYUYjhkgkjhdsgfowe787243KJHGDSAGJKkjgdfuye3sd7"};
		key_rows[3] = {"l45kjhdfuihlIUYSLKHi87ylKJHYOIUmsagKJLHgY9802734KJHLKiuoymNJHTmnb",
			"4iU7687nkmbojyTD64654HJG765KHKJhg87jKHKJ76dcbnmbDBDSJFDHJ6IHGHJ"};
		key_rows[4] = {"fdlkhgljslfkdfhvcxzb 902374jklhfdgoIUOYLSKFDJH98798ysdlk9870OLHL9",
			"87sdxmncosidHGKJ876kjhtdg786JHG87kj76Kjhgkjhi8K8HG98kgdnb mvzms"};
		key_rows[5] = {"lsdhflkasjhLKJHSLKHAFD987435LRKJHL34UY5L34J64MNB7IU4Yiuoyt87sdfjs",
			"hg87ahjkjhgds87JHGKJHT8kjhgdfsvbmyt4eu678JHGkjyt6jKH78k0kjt02KJ"};
		key_rows[6] = {"lkjhUIYkljhlUYOI6yt9876HJMNBVuyt97JKHfMvhjytrfiyIUHGKVBMNBuyi9872",
			"548JKN76kj9fsd8KHG8JKg7872732jK8JgkjhKJHGKJHgkjhg7jkhgkjhgkjhgk"};
		key_rows[7] = {"dsdfLKJH;LKjKJFLdJGmhpi657oU6Y76fhgf5dyfh879346nmzmbvc56erter654g",
			"vcbmzwsdfdsmxcngfvRDFrEDfg76bDewdfvdfgwqsdfdgfcrRDfhgfderfdfteP"};
		key_rows[8] = {"lkhfdsRE546457djh6g65l67KJHLkhmnbvxcbDF09KLJliuyfdsgxcvbFDGERsdas",
			"dfgTEdhFDtYrt8765DFRrfgfhvhghretwRF67654DFhDGFDVctTRTtrytrRyiTY"};
		key_rows[9] = {"28734jsdfhg873jksgUIYTIUkhgiuT7YIGVBKjg8796KHG8o76HJG876tKJHG8976",
			"GFd6584H6G67RT987kJHG65978JKHG8JHGKJHGkhjgkjhgidsytf87439649283"};
		cur_key     = '0;
		key_pos     = '0;
		chain       = '0;
		phase       = kxc_pkg::PH_KEY;
		hold_errors = 1'b0;
		mismatches  = 0;
		accepted    = 0;
	endfunction

	// inverted key byte at the current position, rows past the table read as zero
	function logic [7:0] key_pad();
		logic [7:0] k;
		k = '0;
		if (int'(cur_key) < 10) begin
			k = key_rows[cur_key][8*(127-int'(key_pos)) +: 8];
		end
		return ~k;
	endfunction

	function void step_position();
		key_pos = (int'(key_pos) + 1 >= kxc_pkg::KEY_BYTES_DEF) ? '0 : key_pos + 7'd1;
	endfunction

	function void queue_result(logic [7:0] text, logic dv, logic last, kxc_pkg::status_t st);
		cipher_result_t res;
		res.text       = text;
		res.data_valid = dv;
		res.last       = last;
		res.status     = st;
		pending.push_back(res);
	endfunction

	// advance the predicted cipher state by one accepted request
	function void note_request(cipher_request_t r);
		logic [7:0] b;
		accepted++;
		if (r.op == kxc_pkg::OP_ENCRYPT) begin
			if (r.first) begin
				cur_key = (int'(r.key_sel) >= kxc_pkg::KEY_COUNT_DEF) ?
					4'(kxc_pkg::KEY_COUNT_DEF - 1) : r.key_sel;
				key_pos = (int'(r.start) >= kxc_pkg::KEY_BYTES_DEF) ?
					7'(kxc_pkg::KEY_BYTES_DEF - 1) : r.start;
				queue_result({4'b0, cur_key}, 1'b1, 1'b0, kxc_pkg::ST_OK);
				queue_result({1'b0, key_pos}, 1'b1, 1'b0, kxc_pkg::ST_OK);
				chain       = {1'b0, key_pos};
				hold_errors = 1'b0;
			end
			b = r.data ^ key_pad();
			if (!r.last) begin
				b = b ^ chain;
			end
			chain = b;
			step_position();
			queue_result(b, 1'b1, r.last, kxc_pkg::ST_OK);
			phase = r.last ? kxc_pkg::PH_KEY : kxc_pkg::PH_DATA;
			return;
		end
		if (r.first) begin
			hold_errors = 1'b0;
			phase       = kxc_pkg::PH_KEY;
		end
		if (hold_errors) begin
			if (r.last) begin
				hold_errors = 1'b0;
				phase       = kxc_pkg::PH_KEY;
			end
			return;
		end
		case (phase)
			kxc_pkg::PH_KEY: begin
				if (int'(r.data) >= kxc_pkg::KEY_COUNT_DEF) begin
					queue_result('0, 1'b0, 1'b1, kxc_pkg::ST_BAD_KEY);
					hold_errors = !r.last;
				end else begin
					cur_key = r.data[3:0];
					if (r.last) begin
						queue_result('0, 1'b0, 1'b1, kxc_pkg::ST_BAD_START);
					end else begin
						phase = kxc_pkg::PH_START;
					end
				end
			end
			kxc_pkg::PH_START: begin
				if (int'(r.data) >= kxc_pkg::KEY_BYTES_DEF) begin
					queue_result('0, 1'b0, 1'b1, kxc_pkg::ST_BAD_START);
					hold_errors = !r.last;
					phase       = kxc_pkg::PH_KEY;
				end else begin
					key_pos = r.data[6:0];
					chain   = r.data;
					if (r.last) begin
						queue_result('0, 1'b0, 1'b1, kxc_pkg::ST_OK);
						phase = kxc_pkg::PH_KEY;
					end else begin
						phase = kxc_pkg::PH_DATA;
					end
				end
			end
			default: begin
				b = r.last ? r.data : (r.data ^ chain);
				b = b ^ key_pad();
				chain = r.data;
				step_position();
				queue_result(b, 1'b1, r.last, kxc_pkg::ST_OK);
				phase = r.last ? kxc_pkg::PH_KEY : kxc_pkg::PH_DATA;
			end
		endcase
	endfunction

	task report(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_result(logic [7:0] text, logic dv, logic last, logic [1:0] st);
		cipher_result_t want;
		if (pending.size() == 0) begin
			report($sformatf("result %h with nothing outstanding", text));
			return;
		end
		want = pending.pop_front();
		if (text !== want.text)
			report($sformatf("out_byte %h, predicted %h", text, want.text));
		if (dv !== want.data_valid)
			report($sformatf("data_valid %b, predicted %b", dv, want.data_valid));
		if (last !== want.last)
			report($sformatf("last_out %b, predicted %b", last, want.last));
		if (st !== want.status)
			report($sformatf("status %0d, predicted %0d", st, want.status));
	endtask
endclass

module tb_keyed_xor_chain_byte_cipher;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_ITEMS  = 20;   // last requests go out with no idling on either side
	localparam int HOLD_AT     = 60;   // requests accepted before the long receiver hold-off
	localparam int HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       operation;
	logic [7:0] data_byte;
	logic       first_in;
	logic       last_in;
	logic [3:0] key_select;
	logic [6:0] start_position;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       data_valid;
	logic       last_out;
	logic [1:0] status;

	cipher_scoreboard board;
	cipher_request_t  requests [$];
	bit               quiet_tail;
	bit               holding;
	int               cycles;

	keyed_xor_chain_byte_cipher dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_byte      (data_byte),
		.first_in       (first_in),
		.last_in        (last_in),
		.key_select     (key_select),
		.start_position (start_position),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.data_valid     (data_valid),
		.last_out       (last_out),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// build one request; key and start ride along on every request, only a first encrypt uses them
	task automatic add_request(kxc_pkg::op_t op, logic [7:0] data, logic first, logic last,
			logic [3:0] ks, logic [6:0] sp);
		cipher_request_t r;
		r.op      = op;
		r.data    = data;
		r.first   = first;
		r.last    = last;
		r.key_sel = ks;
		r.start   = sp;
		requests.push_back(r);
	endtask

	// plaintext message of random bytes, key and start only matter with the first mark
	task automatic add_encrypt_message(logic [3:0] ks, logic [6:0] sp, int len, bit mark_first);
		for (int i = 0; i < len; i++) begin
			add_request(kxc_pkg::OP_ENCRYPT, 8'($urandom), (i == 0) && mark_first,
				i == len - 1, (i == 0) ? ks : 4'($urandom), (i == 0) ? sp : 7'($urandom));
		end
	endtask

	// ciphertext message: key byte, start byte, then random data; short lengths truncate the header
	task automatic add_decrypt_message(logic [7:0] key_b, logic [7:0] start_b, int len,
			bit mark_first);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (i == 0) ? key_b : (i == 1) ? start_b : 8'($urandom);
			add_request(kxc_pkg::OP_DECRYPT, b, (i == 0) && mark_first, i == len - 1,
				4'($urandom), 7'($urandom));
		end
	endtask

	// offer one request and hold it until the block takes it
	task automatic offer_request(cipher_request_t r);
		in_valid       <= 1'b1;
		operation      <= r.op;
		data_byte      <= r.data;
		first_in       <= r.first;
		last_in        <= r.last;
		key_select     <= r.key_sel;
		start_position <= r.start;
		do @(posedge clk); while (!in_ready);
		board.note_request(r);
	endtask

	// sender side: stimulus, reset and the end of the run
	initial begin
		int kind;
		int len;
		int n;
		board          = new();
		quiet_tail     = 1'b0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		operation      <= kxc_pkg::OP_ENCRYPT;
		data_byte      <= '0;
		first_in       <= 1'b0;
		last_in        <= 1'b0;
		key_select     <= '0;
		start_position <= '0;

		// directed: single byte encrypt, never chained
		add_request(kxc_pkg::OP_ENCRYPT, 8'h00, 1'b1, 1'b1, 4'd0, 7'd0);
		// key past the table saturates, start at the top wraps the key position
		add_request(kxc_pkg::OP_ENCRYPT, 8'hff, 1'b1, 1'b0, 4'd15, 7'd127);
		add_request(kxc_pkg::OP_ENCRYPT, 8'h55, 1'b0, 1'b0, 4'd0, 7'd0);
		add_request(kxc_pkg::OP_ENCRYPT, 8'haa, 1'b0, 1'b1, 4'd15, 7'd127);
		// encrypt without a first mark carries on from the stored state
		add_encrypt_message(4'd3, 7'd3, 2, 1'b0);
		// good decrypt header at the top key and start, data wraps the position
		add_decrypt_message(8'd9, 8'd127, 4, 1'b1);
		// bad key number, rest of the message dropped
		add_decrypt_message(8'd10, 8'd0, 3, 1'b1);
		// bad start position, rest dropped
		add_decrypt_message(8'd3, 8'd200, 3, 1'b1);
		// message ends right after the key byte
		add_decrypt_message(8'd2, 8'd0, 1, 1'b1);
		// message ends right after the start byte: empty plaintext
		add_decrypt_message(8'd1, 8'd5, 2, 1'b1);
		// a first mark in the middle of a dropped message restarts the header
		add_request(kxc_pkg::OP_DECRYPT, 8'hff, 1'b1, 1'b0, 4'd0, 7'd0);
		add_decrypt_message(8'd0, 8'd0, 3, 1'b1);
		// decrypt without a first mark after a finished message reads a key byte
		add_decrypt_message(8'd4, 8'd9, 2, 1'b0);

		// random part: mostly well formed messages, some broken headers and noise
		n = 120;
		while (requests.size() < n) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				add_encrypt_message(($urandom_range(0, 3) == 0) ? 4'($urandom) :
					4'($urandom_range(0, 9)), 7'($urandom), $urandom_range(1, 6),
					$urandom_range(0, 9) != 0);
			end else if (kind <= 6) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) :
					$urandom_range(3, 7);
				add_decrypt_message(($urandom_range(0, 4) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 9)), ($urandom_range(0, 4) == 0) ? 8'($urandom) :
					8'($urandom_range(0, 127)), len, $urandom_range(0, 7) != 0);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					add_request(kxc_pkg::op_t'($urandom_range(0, 1)), 8'($urandom),
						1'($urandom), 1'($urandom), 4'($urandom), 7'($urandom));
				end
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (requests[i]) begin
			quiet_tail = (i >= requests.size() - TAIL_ITEMS);
			// idle bursts, but keep offering while the receiver is held off
			if (!quiet_tail && !holding && $urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			offer_request(requests[i]);
		end
		in_valid <= 1'b0;

		// drain, then give a late stray result time to show up
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// receiver side: checks results, random stalls and one long hold-off
	initial begin
		int   stall_left;
		int   hold_left;
		bit   held;
		logic ready_next;
		stall_left = 0;
		hold_left  = 0;
		held       = 1'b0;
		holding    = 1'b0;
		out_ready  <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_result(out_byte, data_valid, last_out, status);
			// once into the run, stop taking results long enough to back up the input
			if (!held && board.accepted >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (stall_left > 0 && !quiet_tail) begin
				stall_left--;
				ready_next = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			holding   = hold_left > 0;
			out_ready <= ready_next;
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
sv/kxc_pkg.sv
sv/kxc_key_rom.sv
sv/kxc_ctrl.sv
sv/kxc_out.sv
sv/keyed_xor_chain_byte_cipher.sv
dv/tb_keyed_xor_chain_byte_cipher.sv
